[hdl/rmv_pkg.sv]
// Shared types and constants for the running mean and variance block.
// Holds the payload structs, the fixed-point formats and the format helper.
// No dependencies.
package rmv_pkg;

  localparam int SAMPLE_FRAC_BITS = 16;
  localparam int MEAN_FRAC_BITS   = 17;
  localparam int VAR_FRAC_BITS    = 7;

  localparam int SAMPLE_W = 32;
  localparam int MEAN_W   = 32;
  localparam int SUM_W    = 31;
  localparam int COUNT_W  = 16;

  // The serial divider and multiplier work on 33-bit magnitudes, since a
  // difference of two 32-bit signed values can reach 2^32 - 1 in magnitude.
  localparam int DIV_W = 33;
  localparam int MUL_W = 33;

  localparam logic ACT_ADD     = 1'b0;
  localparam logic ACT_RESTART = 1'b1;

  typedef struct packed {
    logic              action;
    logic signed [SAMPLE_W-1:0] sample;
  } rmv_item_t;

  typedef struct packed {
    logic signed [MEAN_W-1:0] mean;
    logic [SUM_W-1:0]         sum_sq_dev;
    logic [SUM_W-1:0]         variance;
    logic                     variance_valid;
    logic [COUNT_W-1:0]       count;
  } rmv_result_t;

  // Moves a 32-bit value between fraction formats. Going up shifts left and
  // saturates; going down is an arithmetic shift, which rounds toward minus
  // infinity. The shift amounts are constants, so this is wiring plus a clamp.
  function automatic logic signed [31:0] reformat(input logic signed [31:0] v,
                                                  input int from_fb,
                                                  input int to_fb);
    logic signed [63:0] wide;
    logic signed [31:0] res;
    wide = {{32{v[31]}}, v};
    if (to_fb >= from_fb) begin
      wide = wide <<< (to_fb - from_fb);
      if (wide > 64'sh0000_0000_7FFF_FFFF) begin
        res = 32'sh7FFF_FFFF;
      end else if (wide < 64'shFFFF_FFFF_8000_0000) begin
        res = 32'sh8000_0000;
      end else begin
        res = wide[31:0];
      end
    end else begin
      wide = wide >>> (from_fb - to_fb);
      res  = wide[31:0];
    end
    return res;
  endfunction

endpackage

[hdl/rmv_divider.sv]
// Radix-2 restoring divider, one quotient bit per cycle.
// Unsigned 33-bit dividend by a nonzero 16-bit divisor.
// Depends on rmv_pkg.
module rmv_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [rmv_pkg::DIV_W-1:0]   dividend,
  input  logic [rmv_pkg::COUNT_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [rmv_pkg::DIV_W-1:0]   quotient
);
  import rmv_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] dvs;
  logic [DIV_W-1:0]   qsh;
  logic [STEP_W-1:0]  steps;
  logic [COUNT_W:0]   trial_in;
  logic [COUNT_W:0]   trial;
  logic               ge;

  // The dividend shifts out at the top of qsh while quotient bits enter below.
  assign trial_in = {rem, qsh[DIV_W-1]};
  assign ge       = trial_in >= {1'b0, dvs};
  assign trial    = trial_in - {1'b0, dvs};
  assign quotient = qsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIV_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      qsh <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? trial[COUNT_W-1:0] : trial_in[COUNT_W-1:0];
      qsh <= {qsh[DIV_W-2:0], ge};
    end
  end

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) busy |-> rem < dvs)
    else $error("partial remainder not below divisor");
  a_ends_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (busy || done))
    else $error("divider stopped without done");
`endif

endmodule

[hdl/rmv_mult.sv]
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Unsigned 33 by 33 bits to a 66-bit product.
// Depends on rmv_pkg.
module rmv_mult (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [rmv_pkg::MUL_W-1:0]   a,
  input  logic [rmv_pkg::MUL_W-1:0]   b,
  output logic                        busy,
  output logic                        done,
  output logic [2*rmv_pkg::MUL_W-1:0] product
);
  import rmv_pkg::*;

  localparam int STEP_W = $clog2(MUL_W + 1);

  logic [MUL_W-1:0]  hi;
  logic [MUL_W-1:0]  lo;
  logic [MUL_W-1:0]  mcand;
  logic [MUL_W:0]    part;
  logic [STEP_W-1:0] steps;

  // Add the multiplicand when the current multiplier bit is set, then shift
  // the whole hi:lo pair right by one; lo ends up holding the low half.
  assign part    = {1'b0, hi} + {1'b0, (lo[0] ? mcand : {MUL_W{1'b0}})};
  assign product = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(MUL_W);
      end else if (busy) begin
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= b;
      mcand <= a;
    end else if (busy) begin
      hi <= part[MUL_W:1];
      lo <= {part[0], lo[MUL_W-1:1]};
    end
  end

`ifndef ASSERT_OFF
  a_no_restart: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("multiplier started while busy");
  a_ends_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> (busy || done))
    else $error("multiplier stopped without done");
`endif

endmodule

[hdl/running_mean_variance.sv]
// Top level of the fixed-point running mean and variance block.
// Depends on rmv_pkg, rmv_divider and rmv_mult.
//
//   channel   signals                          carries
//   -------   -------------------------------  ------------------------------
//   item      item_valid, item_ready, item     action and sample, one request
//   result    result_valid, result_ready,      mean, sum, variance, valid flag
//             result                           and count, one per request
//
// A restart request goes from idle straight to the finish state, which loads
// the result register once it is free and returns to idle. An add request
// runs through the prepare state, one 33-step division for the mean update,
// the multiply prepare state, one 33-step multiplication for the deviation
// product, the variance start state, one 33-step division for the variance
// and the finish state, each unit working a bit per cycle. An add that leaves
// the count below two skips the variance division.
// Reset (synchronous, active high) clears the mean, the sum and the count.
// The result register holds a finished result while the next request is
// already being worked on; the block only waits at the end if it is still full.
module running_mean_variance (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  rmv_pkg::rmv_item_t   item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output rmv_pkg::rmv_result_t result
);
  import rmv_pkg::*;

  // Magnitude cap on one product term, and the saturation point of the sum.
  localparam logic [40:0]        TERM_CAP = 41'h100_0000_0000;
  localparam logic signed [42:0] SUM_MAX  = 43'sh000_7FFF_FFFF;

  typedef enum logic [7:0] {
    ST_IDLE      = 8'b0000_0001,
    ST_PREP      = 8'b0000_0010,
    ST_DIV_MEAN  = 8'b0000_0100,
    ST_MUL_PREP  = 8'b0000_1000,
    ST_MUL       = 8'b0001_0000,
    ST_VAR_START = 8'b0010_0000,
    ST_DIV_VAR   = 8'b0100_0000,
    ST_FINISH    = 8'b1000_0000
  } state_t;

  state_t state;

  // Running statistics.
  logic signed [MEAN_W-1:0] mean;
  logic [SUM_W-1:0]         sum;
  logic [COUNT_W-1:0]       count;

  // Per-request working registers.
  logic signed [SAMPLE_W-1:0] smp;
  logic signed [MEAN_W-1:0]   old_mean;
  logic                       mean_neg;
  logic                       prod_neg;
  logic [SUM_W-1:0]           variance;
  logic                       var_valid;

  // Serial units.
  logic                 div_start;
  logic [DIV_W-1:0]     div_dividend;
  logic [COUNT_W-1:0]   div_divisor;
  logic                 div_busy;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quotient;
  logic                 mul_start;
  logic [MUL_W-1:0]     mul_a;
  logic [MUL_W-1:0]     mul_b;
  logic                 mul_busy;
  logic                 mul_done;
  logic [2*MUL_W-1:0]   mul_product;

  // Datapath values.
  logic                       accept;
  logic                       can_load;
  logic                       count_ge2;
  logic signed [MEAN_W-1:0]   smp_m;
  logic signed [DIV_W-1:0]    diff;
  logic [DIV_W-1:0]           diff_mag;
  logic signed [DIV_W:0]      q_signed;
  logic signed [DIV_W:0]      new_mean_w;
  logic signed [MEAN_W-1:0]   new_mean;
  logic signed [31:0]         sv;
  logic signed [31:0]         ov;
  logic signed [31:0]         nv;
  logic signed [MUL_W-1:0]    d1;
  logic signed [MUL_W-1:0]    d2;
  logic [2*MUL_W-1:0]         p_shift;
  logic                       p_ovf;
  logic [40:0]                term_mag;
  logic signed [42:0]         term_s;
  logic signed [42:0]         sum_w;
  logic [SUM_W-1:0]           sum_new;

  assign accept     = item_valid && item_ready;
  assign item_ready = (state == ST_IDLE);
  assign can_load   = !result_valid || result_ready;
  assign count_ge2  = count >= COUNT_W'(2);

  // Mean update: the sample in mean format, its distance from the old mean,
  // and the truncated quotient added back with its sign.
  always_comb begin
    smp_m      = reformat(smp, SAMPLE_FRAC_BITS, MEAN_FRAC_BITS);
    diff       = {smp_m[MEAN_W-1], smp_m} - {old_mean[MEAN_W-1], old_mean};
    diff_mag   = diff[DIV_W-1] ? DIV_W'(-diff) : DIV_W'(diff);
    q_signed   = mean_neg ? -$signed({1'b0, div_quotient}) : $signed({1'b0, div_quotient});
    new_mean_w = $signed({{2{old_mean[MEAN_W-1]}}, old_mean}) + q_signed;
    if (new_mean_w > 34'sh0_7FFF_FFFF) begin
      new_mean = 32'sh7FFF_FFFF;
    end else if (new_mean_w < 34'sh3_8000_0000) begin
      new_mean = 32'sh8000_0000;
    end else begin
      new_mean = new_mean_w[MEAN_W-1:0];
    end
  end

  // Deviation product: (sample - old mean) * (sample - new mean) in the
  // variance format, taken as magnitudes with the sign kept aside.
  always_comb begin
    sv    = reformat(smp, SAMPLE_FRAC_BITS, VAR_FRAC_BITS);
    ov    = reformat(old_mean, MEAN_FRAC_BITS, VAR_FRAC_BITS);
    nv    = reformat(mean, MEAN_FRAC_BITS, VAR_FRAC_BITS);
    d1    = {sv[31], sv} - {ov[31], ov};
    d2    = {sv[31], sv} - {nv[31], nv};
    mul_a = d1[MUL_W-1] ? MUL_W'(-d1) : MUL_W'(d1);
    mul_b = d2[MUL_W-1] ? MUL_W'(-d2) : MUL_W'(d2);
  end

  // Product term and sum update. A product that does not fit 63 bits is
  // treated as the cap outright, before the fraction bits are dropped.
  always_comb begin
    p_ovf   = |mul_product[2*MUL_W-1:63];
    p_shift = mul_product >> VAR_FRAC_BITS;
    if (p_ovf || (p_shift > (2*MUL_W)'(TERM_CAP))) begin
      term_mag = TERM_CAP;
    end else begin
      term_mag = p_shift[40:0];
    end
    term_s = prod_neg ? -$signed({2'b0, term_mag}) : $signed({2'b0, term_mag});
    sum_w  = $signed({12'b0, sum}) + term_s;
    if (sum_w < 0) begin
      sum_new = '0;
    end else if (sum_w > SUM_MAX) begin
      sum_new = '1;
    end else begin
      sum_new = sum_w[SUM_W-1:0];
    end
  end

  // The divider serves the mean step first and the variance later.
  always_comb begin
    div_start = (state == ST_PREP) || ((state == ST_VAR_START) && count_ge2);
    if (state == ST_PREP) begin
      div_dividend = diff_mag;
      div_divisor  = count;
    end else begin
      div_dividend = {2'b0, sum};
      div_divisor  = count - COUNT_W'(1);
    end
    mul_start = (state == ST_MUL_PREP);
  end

  rmv_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quotient)
  );

  rmv_mult u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .done    (mul_done),
    .product (mul_product)
  );

  // Sequencer and running state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      mean  <= '0;
      sum   <= '0;
      count <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (item.action == ACT_RESTART) begin
              mean  <= reformat(item.sample, SAMPLE_FRAC_BITS, MEAN_FRAC_BITS);
              sum   <= '0;
              count <= COUNT_W'(1);
              state <= ST_FINISH;
            end else begin
              // The count stops at its maximum; later samples divide by it.
              if (count != '1) begin
                count <= count + COUNT_W'(1);
              end
              state <= ST_PREP;
            end
          end
        end
        ST_PREP: begin
          state <= ST_DIV_MEAN;
        end
        ST_DIV_MEAN: begin
          if (div_done) begin
            mean  <= new_mean;
            state <= ST_MUL_PREP;
          end
        end
        ST_MUL_PREP: begin
          state <= ST_MUL;
        end
        ST_MUL: begin
          if (mul_done) begin
            sum   <= sum_new;
            state <= ST_VAR_START;
          end
        end
        ST_VAR_START: begin
          state <= count_ge2 ? ST_DIV_VAR : ST_FINISH;
        end
        ST_DIV_VAR: begin
          if (div_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          if (can_load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Per-request registers carry no reset; each is written before it is used.
  always_ff @(posedge clk) begin
    if (accept) begin
      smp       <= item.sample;
      old_mean  <= mean;
      variance  <= '0;
      var_valid <= 1'b0;
    end
    if (state == ST_PREP) begin
      mean_neg <= diff[DIV_W-1];
    end
    if (state == ST_MUL_PREP) begin
      prod_neg <= d1[MUL_W-1] ^ d2[MUL_W-1];
    end
    if ((state == ST_DIV_VAR) && div_done) begin
      variance  <= div_quotient[SUM_W-1:0];
      var_valid <= 1'b1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if ((state == ST_FINISH) && can_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && can_load) begin
      result.mean           <= mean;
      result.sum_sq_dev     <= sum;
      result.variance       <= variance;
      result.variance_valid <= var_valid;
      result.count          <= count;
    end
  end

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !item_ready)
    else $error("block still idle after taking a request");
  a_valid_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.variance_valid == (result.count >= COUNT_W'(2))))
    else $error("variance flag disagrees with count");
  a_short_run_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.variance_valid) |-> (result.variance == '0))
    else $error("variance nonzero for a short run");
  a_units_apart: assert property (@(posedge clk) disable iff (rst)
    mul_busy |-> !div_busy)
    else $error("divider and multiplier active together");
`endif

endmodule

[test/running_mean_variance_tb.sv]
// Self-checking testbench for the running mean and variance block.
// Depends on rmv_pkg (payload structs, formats, action codes) and the
// running_mean_variance top level; needs nothing else.
`timescale 1ns / 100ps

module running_mean_variance_tb;
  import rmv_pkg::*;

  // Every request is answered well inside the idle limit, so a quiet spell
  // that reaches it can only mean the block is stuck.
  localparam int IDLE_LIMIT    = 3000;
  localparam int SETTLE_CYCLES = 150;
  localparam int RANDOM_ITEMS  = 550;

  localparam longint S32_MAX  = 64'sh0000_0000_7FFF_FFFF;
  localparam longint S32_MIN  = -S32_MAX - 1;
  localparam longint SUM_CEIL = S32_MAX;
  localparam longint RUN_CAP  = 65535;

  logic        clk;
  logic        rst          = 1'b1;
  logic        item_valid   = 1'b0;
  logic        item_ready;
  rmv_item_t   item         = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  rmv_result_t result;

  running_mean_variance dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Running statistics as the block should hold them: the mean in the mean
  // format, the sum of squared deviations in the variance format, and the
  // number of samples in the current run.
  longint run_mean = 0;
  longint run_sum  = 0;
  longint run_len  = 0;

  // Statistics the block owes us, oldest request first.
  rmv_result_t pending_stats[$];

  int mismatches    = 0;
  int requests_sent = 0;
  int restarts_sent = 0;
  int longest_run   = 0;
  int saturated_sum = 0;
  int idle_cycles   = 0;
  int ready_hold    = 0;
  bit calm          = 1'b0;  // when set, neither side inserts gaps

  function automatic longint clamp_s32(longint v);
    if (v > S32_MAX) return S32_MAX;
    if (v < S32_MIN) return S32_MIN;
    return v;
  endfunction

  // Moving to more fraction bits saturates; moving to fewer is an arithmetic
  // shift, which floors negative values.
  function automatic longint to_format(longint v, int from_fb, int to_fb);
    if (to_fb >= from_fb) return clamp_s32(v <<< (to_fb - from_fb));
    return v >>> (from_fb - to_fb);
  endfunction

  // One Welford step, or a restart, on the predicted state; returns what the block must report.
  function automatic rmv_result_t advance_stats(logic act, logic signed [31:0] s);
    longint x, prior, x_mean, x_var, prior_var, now_var, d_prior, d_now, mag, quot;
    rmv_result_t r;
    x = longint'(s);
    r = '0;
    if (act == ACT_RESTART) begin
      run_mean = to_format(x, SAMPLE_FRAC_BITS, MEAN_FRAC_BITS);
      run_sum  = 0;
      run_len  = 1;
    end else begin
      prior = run_mean;
      if (run_len < RUN_CAP) run_len++;
      x_mean   = to_format(x, SAMPLE_FRAC_BITS, MEAN_FRAC_BITS);
      // Signed division truncates toward zero, as the mean step requires.
      run_mean = clamp_s32(prior + (x_mean - prior) / run_len);
      x_var     = to_format(x, SAMPLE_FRAC_BITS, VAR_FRAC_BITS);
      prior_var = to_format(prior, MEAN_FRAC_BITS, VAR_FRAC_BITS);
      now_var   = to_format(run_mean, MEAN_FRAC_BITS, VAR_FRAC_BITS);
      d_prior   = x_var - prior_var;
      d_now     = x_var - now_var;
      // Both deviations stay below 2^24 in magnitude, so the product fits in
      // 64 bits and never comes near the 2^40 cap on the term.
      mag = ((d_prior < 0 ? -d_prior : d_prior) * (d_now < 0 ? -d_now : d_now))
            >>> VAR_FRAC_BITS;
      run_sum += ((d_prior < 0) != (d_now < 0)) ? -mag : mag;
      if (run_sum < 0) run_sum = 0;
      else if (run_sum > SUM_CEIL) run_sum = SUM_CEIL;
    end
    r.mean       = run_mean[31:0];
    r.sum_sq_dev = run_sum[SUM_W-1:0];
    r.count      = run_len[COUNT_W-1:0];
    if (run_len >= 2) begin
      quot             = run_sum / (run_len - 1);
      r.variance       = quot[SUM_W-1:0];
      r.variance_valid = 1'b1;
    end
    return r;
  endfunction

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 200);
  endfunction

  function automatic logic [31:0] pick_center();
    if ($urandom_range(0, 1) == 0) return $urandom();
    return $urandom_range(0, 1 << 22) - (1 << 21);
  endfunction

  // Samples cluster around the run's center so that the variance stays
  // meaningful, with full-range values and extremes mixed in.
  function automatic logic [31:0] draw_sample(logic [31:0] center);
    logic [31:0] spread;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          3: return 32'hFFFF_FFFF;
          default: return 32'h0000_0001;
        endcase
      end
      1, 2: return $urandom();
      default: begin
        spread = 32'd1 << $urandom_range(4, 24);
        return center + $urandom_range(0, spread) - (spread >> 1);
      end
    endcase
  endfunction

  // Presents one request, holds it until the block takes it, then records the
  // statistics the block has to answer with. A typed-in expectation, when
  // given, replaces the predicted one; the predicted state still advances.
  task automatic send_sample(logic act, logic [31:0] smp, logic known,
                             rmv_result_t want);
    int gap;
    rmv_result_t predicted;
    gap = pick_gap();
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= {act, smp};
    do @(posedge clk); while (!item_ready);
    predicted = advance_stats(act, smp);
    pending_stats.push_back(known ? want : predicted);
    requests_sent++;
    if (act == ACT_RESTART) restarts_sent++;
  endtask

  task automatic compare_field(string field, longint want, longint got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Directed requests. Rows marked known carry a result that can be read off
  // directly: the first sample of an empty run, restarts (including ones whose
  // conversion to the mean format saturates), and a zero-spread pair. All other
  // rows go through the predictor.
  typedef struct packed {
    logic        action;
    logic [31:0] sample;
    logic        known;
    rmv_result_t want;
  } stim_row_t;

  localparam rmv_result_t NO_RESULT = '0;
  localparam int N_DIRECTED = 20;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // An add right after reset acts as the first sample of a run.
    {ACT_ADD,     32'h0001_0000, 1'b1, {32'h0002_0000, 31'd0, 31'd0, 1'b0, 16'd1}},
    {ACT_ADD,     32'h0003_0000, 1'b0, NO_RESULT},
    {ACT_ADD,     32'hFFFD_8000, 1'b0, NO_RESULT},
    // Negative values lose fraction bits by flooring.
    {ACT_ADD,     32'hFFFF_FFFF, 1'b0, NO_RESULT},
    {ACT_ADD,     32'h0000_0001, 1'b0, NO_RESULT},
    {ACT_RESTART, 32'h7FFF_FFFF, 1'b1, {32'h7FFF_FFFF, 31'd0, 31'd0, 1'b0, 16'd1}},
    {ACT_ADD,     32'h8000_0000, 1'b0, NO_RESULT},
    {ACT_ADD,     32'h7FFF_FFFF, 1'b0, NO_RESULT},
    {ACT_RESTART, 32'h8000_0000, 1'b1, {32'h8000_0000, 31'd0, 31'd0, 1'b0, 16'd1}},
    // Opposite extremes drive the sum into saturation.
    {ACT_ADD,     32'h7FFF_FFFF, 1'b0, NO_RESULT},
    {ACT_ADD,     32'h0000_0000, 1'b0, NO_RESULT},
    {ACT_RESTART, 32'h0000_0000, 1'b1, {32'h0000_0000, 31'd0, 31'd0, 1'b0, 16'd1}},
    {ACT_ADD,     32'h0000_0000, 1'b1, {32'h0000_0000, 31'd0, 31'd0, 1'b1, 16'd2}},
    {ACT_ADD,     32'h0000_0001, 1'b0, NO_RESULT},
    {ACT_ADD,     32'hFFFF_FFFF, 1'b0, NO_RESULT},
    // These two overflow the signed range when moved to the mean format.
    {ACT_RESTART, 32'h4000_0000, 1'b1, {32'h7FFF_FFFF, 31'd0, 31'd0, 1'b0, 16'd1}},
    {ACT_RESTART, 32'hBFFF_FFFF, 1'b1, {32'h8000_0000, 31'd0, 31'd0, 1'b0, 16'd1}},
    {ACT_ADD,     32'h5555_5555, 1'b0, NO_RESULT},
    {ACT_ADD,     32'hAAAA_AAAA, 1'b0, NO_RESULT},
    {ACT_ADD,     32'h0000_0200, 1'b0, NO_RESULT}
  };

  // Result side: after each accepted result the receiver may stall for a
  // random stretch, so stalls land on every phase of the next computation.
  always @(posedge clk) begin : result_backpressure
    int stall;
    if (rst) begin
      result_ready <= 1'b0;
      ready_hold   <= 0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (result_valid && result_ready) begin
      stall = pick_gap();
      if (stall > 0) begin
        result_ready <= 1'b0;
        ready_hold   <= stall - 1;
      end
    end else begin
      result_ready <= 1'b1;
    end
  end

  // Every accepted result is matched against the oldest outstanding request.
  always @(posedge clk) begin : check_results
    rmv_result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_stats.size() == 0) begin
        $display("%0t ns: result with no request outstanding, expected none, actual mean %0d count %0d",
                 $time, result.mean, result.count);
        mismatches++;
      end else begin
        want = pending_stats.pop_front();
        compare_field("mean", longint'(want.mean), longint'(result.mean));
        compare_field("sum_sq_dev", longint'(want.sum_sq_dev), longint'(result.sum_sq_dev));
        compare_field("variance", longint'(want.variance), longint'(result.variance));
        compare_field("variance_valid", longint'(want.variance_valid),
                      longint'(result.variance_valid));
        compare_field("count", longint'(want.count), longint'(result.count));
        if (int'(result.count) > longest_run) longest_run = int'(result.count);
        if (result.sum_sq_dev == {SUM_W{1'b1}}) saturated_sum++;
      end
    end
  end

  // Stops a hung run: any handshake on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_stats.size());
      $display("FAIL running_mean_variance");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [31:0] center;
    logic [31:0] smp;
    logic        act;
    center = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < N_DIRECTED; i++) begin
      send_sample(DIRECTED[i].action, DIRECTED[i].sample, DIRECTED[i].known,
                  DIRECTED[i].want);
    end

    // Random runs: mostly adds around a center that moves on each restart,
    // with one stretch in which both sides run without gaps.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      calm = (k >= 200 && k < 280);
      if ($urandom_range(0, 24) == 0) begin
        act    = ACT_RESTART;
        center = pick_center();
      end else begin
        act = ACT_ADD;
      end
      smp = draw_sample(center);
      send_sample(act, smp, 1'b0, NO_RESULT);
    end
    item_valid <= 1'b0;

    while (pending_stats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d requests, %0d of them restarts; longest run %0d samples.",
             requests_sent, restarts_sent, longest_run);
    $display("%0d results reported a saturated sum; %0d field mismatches.",
             saturated_sum, mismatches);
    if (mismatches == 0) begin
      $display("PASS running_mean_variance");
    end else begin
      $display("FAIL running_mean_variance");
    end
    $finish;
  end

endmodule

[files.f]
hdl/rmv_pkg.sv
hdl/rmv_divider.sv
hdl/rmv_mult.sv
hdl/running_mean_variance.sv
test/running_mean_variance_tb.sv
